@@ rtl/sitda_pkg.sv @@
// Shared types, constants and the BCD adjust function for the integer-to-decimal converter.
package sitda_pkg;

    localparam int VALUE_W    = 64;
    localparam int NUM_DIGITS = 20;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = $clog2(VALUE_W);
    localparam int IDX_W      = $clog2(NUM_DIGITS);

    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(VALUE_W - 1);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_FIND,
        ST_SIGN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
        logic find;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic bit_done;
        logic idx_zero;
        logic negative;
        logic out_free;
    } t_status;

    // add-3 correction on every digit of 5 or more, ahead of the next shift
    function automatic logic [BCD_W-1:0] dd_adjust(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0] res;
        res = bcd;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd[4*i +: 4] >= 4'd5) begin
                res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/sitda_ctrl.sv @@
// Sequencing controller: load, double-dabble shifts, leading digit search, character output.
module sitda_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  sitda_pkg::t_status i_status,
    output sitda_pkg::t_cmd    o_cmd
);
    import sitda_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_CONV;
            ST_CONV: if (i_status.bit_done) n_state = ST_FIND;
            ST_FIND: n_state = i_status.negative ? ST_SIGN : ST_EMIT;
            ST_SIGN: if (i_status.out_free) n_state = ST_EMIT;
            ST_EMIT: if (i_status.out_free && i_status.idx_zero) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            ST_CONV: o_cmd.shift = 1'b1;
            ST_FIND: o_cmd.find = 1'b1;
            ST_SIGN: o_cmd.emit_sign = i_status.out_free;
            ST_EMIT: o_cmd.emit_digit = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ rtl/sitda_dp.sv @@
// Datapath: magnitude and BCD shift registers, digit index and output word register.
module sitda_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic signed [sitda_pkg::VALUE_W-1:0] i_value,
    input  sitda_pkg::t_cmd                      i_cmd,
    output sitda_pkg::t_status                   o_status,
    output logic [7:0]                           o_character,
    output logic                                 o_last,
    output logic                                 o_valid,
    input  logic                                 i_stall
);
    import sitda_pkg::*;

    logic [VALUE_W-1:0] r_mag;
    logic [BCD_W-1:0]   r_bcd;
    logic [CNT_W-1:0]   r_bit_cnt;
    logic [IDX_W-1:0]   r_idx;
    logic               r_neg;
    logic               r_out_valid;
    logic [7:0]         r_character;
    logic               r_last;

    logic [VALUE_W-1:0] w_mag_in;
    logic [BCD_W-1:0]   w_adj;
    logic [IDX_W-1:0]   w_lead;
    logic [3:0]         w_digit;

    assign w_mag_in = i_value[VALUE_W-1] ? ('0 - $unsigned(i_value)) : $unsigned(i_value);
    assign w_adj    = dd_adjust(r_bcd);
    assign w_digit  = r_bcd[{r_idx, 2'b00} +: 4];

    // highest non-zero digit; zero itself leaves index 0
    always_comb begin
        w_lead = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                w_lead = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg     <= i_value[VALUE_W-1];
            r_mag     <= w_mag_in;
            r_bcd     <= '0;
            r_bit_cnt <= '0;
        end else if (i_cmd.shift) begin
            r_bcd     <= {w_adj[BCD_W-2:0], r_mag[VALUE_W-1]};
            r_mag     <= {r_mag[VALUE_W-2:0], 1'b0};
            r_bit_cnt <= r_bit_cnt + 1'b1;
        end

        if (i_cmd.find) begin
            r_idx <= w_lead;
        end else if (i_cmd.emit_digit) begin
            r_idx <= r_idx - 1'b1;
        end

        if (i_cmd.emit_sign) begin
            r_character <= CH_MINUS;
            r_last      <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_character <= CH_ZERO + {4'd0, w_digit};
            r_last      <= (r_idx == '0);
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.bit_done = (r_bit_cnt == LAST_BIT);
    assign o_status.idx_zero = (r_idx == '0);
    assign o_status.negative = r_neg;
    assign o_status.out_free = !r_out_valid || !i_stall;

    assign o_valid     = r_out_valid;
    assign o_character = r_character;
    assign o_last      = r_last;

`ifndef SYNTH
    // the search must land on a non-zero leading digit, except for the value zero
    a_lead_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.find |=> (r_idx == '0 || w_digit != 4'd0))
        else $error("leading digit search picked a zero digit");

    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_sign || i_cmd.emit_digit) |=>
            (r_character == CH_MINUS || (r_character >= CH_ZERO && r_character <= CH_NINE)))
        else $error("character outside sign and digit set");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_character == CH_MINUS) |-> !o_last)
        else $error("sign word marked as last");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !(i_cmd.emit_sign || i_cmd.emit_digit))
        else $error("stalled output word overwritten");
`endif

endmodule

@@ rtl/signed_int_to_decimal_ascii_top.sv @@
// Top level: signed 64-bit integer to decimal ASCII text converter.
// One value is taken when i_valid is high and o_stall is low; it is then loaded, shifted
// through the 20-digit BCD register by double dabble, one shift per bit of the magnitude,
// then the leading digit is found, then one character per cycle follows ('-' first for a
// negative value, no leading zeros, '0' for zero, o_last on the final digit), slowed
// only by i_stall. o_stall is high throughout, and the next value is taken once the last
// character has entered the output register.
module signed_int_to_decimal_ascii_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [sitda_pkg::VALUE_W-1:0] i_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [7:0]                           o_character,
    output logic                                 o_last
);
    import sitda_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    sitda_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    sitda_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_character (o_character),
        .o_last      (o_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall)
    );

endmodule

@@ tb/sv/signed_int_to_decimal_ascii_top_tb.sv @@
// Testbench for the signed 64-bit integer to decimal ASCII converter.
module signed_int_to_decimal_ascii_top_tb;

    import sitda_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic signed [VALUE_W-1:0]   i_value;
    logic                        o_valid;
    logic                        i_stall;
    logic [7:0]                  o_character;
    logic                        o_last;

    logic signed [VALUE_W-1:0] word_q[$];   // words still to send
    bit                        hold_q[$];   // 1: wait for all text before sending
    t_text_char                text_q[$];   // characters still to come
    int                        errors;
    int                        tx_gap;
    int                        rx_run;
    bit                        tx_quiet;
    bit                        rx_quiet;

    signed_int_to_decimal_ascii_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

    always #4 i_clk = ~i_clk;

    // Decimal text of one word, appended to the queue of characters to come
    function automatic void format_decimal(input logic signed [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] mag;
        logic [7:0]         digs[NUM_DIGITS];
        int                 n;
        logic               neg;
        t_text_char         c;
        n   = 0;
        neg = v[VALUE_W-1];
        mag = neg ? (VALUE_W'(0) - VALUE_W'(v)) : VALUE_W'(v);
        if (mag == 0) begin
            digs[n] = CH_ZERO;
            n++;
        end
        while (mag != 0 && n < NUM_DIGITS) begin
            digs[n] = CH_ZERO + 8'(mag % 10);
            mag     = mag / 10;
            n++;
        end
        if (neg) begin
            c.ch   = CH_MINUS;
            c.last = 1'b0;
            text_q.push_back(c);
        end
        for (int k = n - 1; k >= 0; k--) begin
            c.ch   = digs[k];
            c.last = (k == 0);
            text_q.push_back(c);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)      return 0;
        else if (r < 85) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 20);
        else             return $urandom_range(40, 150);
    endfunction

    function automatic logic signed [VALUE_W-1:0] rand_value();
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] p;
        int                 k;
        case ($urandom_range(0, 3))
            0: begin
                v = {$urandom, $urandom};
            end
            1: begin
                // small and mid magnitudes of either sign
                v = {$urandom, $urandom} >> $urandom_range(1, 63);
                if ($urandom_range(0, 1)) v = VALUE_W'(0) - v;
            end
            2: begin
                // around powers of ten, where the digit count changes
                p = 1;
                k = $urandom_range(0, 18);
                repeat (k) p = p * 10;
                v = p + VALUE_W'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1)) v = VALUE_W'(0) - v;
            end
            default: begin
                v = {1'b0, {(VALUE_W-1){1'b1}}} - VALUE_W'($urandom_range(0, 1000));
                if ($urandom_range(0, 1)) v = ~v;
            end
        endcase
        return v;
    endfunction

    task automatic add_word(input logic signed [VALUE_W-1:0] v, input bit hold);
        word_q.push_back(v);
        hold_q.push_back(hold);
    endtask

    // Sender: presents queued words, random gaps between them
    always @(posedge i_clk) begin : drive_words
        logic nv;
        nv = i_valid;
        if (!i_rst_n) begin
            nv     = 1'b0;
            tx_gap = 0;
        end else begin
            if (i_valid && !o_stall) begin
                format_decimal(i_value);
                nv = 1'b0;
                if ($urandom_range(0, 14) == 0) tx_quiet = ~tx_quiet;
                tx_gap = tx_quiet ? 0 : pick_gap();
            end
            if (!nv) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (word_q.size() > 0 && !(hold_q[0] && text_q.size() > 0)) begin
                    nv = 1'b1;
                    i_value <= word_q.pop_front();
                    void'(hold_q.pop_front());
                end
            end
        end
        i_valid <= nv;
    end

    // Receiver: random back-pressure and checking of every character taken
    always @(posedge i_clk) begin : check_text
        t_text_char want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (text_q.size() == 0) begin
                $display("%0t: unexpected character: expected none, actual %h last %b",
                         $time, o_character, o_last);
                errors++;
            end else begin
                want = text_q.pop_front();
                if (o_character !== want.ch) begin
                    $display("%0t: character mismatch: expected %h, actual %h",
                             $time, want.ch, o_character);
                    errors++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, want.last, o_last);
                    errors++;
                end
            end
        end
        if ($urandom_range(0, 199) == 0) rx_quiet = ~rx_quiet;
        if (rx_run > 0) begin
            rx_run--;
            i_stall <= 1'b1;
        end else if (rx_quiet || $urandom_range(0, 99) < 70) begin
            i_stall <= 1'b0;
        end else begin
            rx_run  = ($urandom_range(0, 99) < 96) ? $urandom_range(0, 2)
                                                   : $urandom_range(20, 60);
            i_stall <= 1'b1;
        end
    end

    initial begin
        i_clk    = 1'b0;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_value  = '0;
        i_stall  = 1'b0;
        errors   = 0;
        tx_gap   = 0;
        rx_run   = 0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        // directed: zero, extremes, digit-count edges, bit patterns
        add_word(64'sd0, 1'b0);
        add_word(64'sd1, 1'b0);
        add_word(-64'sd1, 1'b0);
        add_word(64'sd9, 1'b0);
        add_word(64'sd10, 1'b0);
        add_word(-64'sd10, 1'b0);
        add_word(64'sd99, 1'b0);
        add_word(64'sd100, 1'b0);
        add_word(64'h7fff_ffff_ffff_ffff, 1'b0);
        add_word(64'h8000_0000_0000_0000, 1'b0);
        add_word(64'h8000_0000_0000_0001, 1'b1);
        add_word(64'sd999_999_999_999_999_999, 1'b0);
        add_word(64'sd1_000_000_000_000_000_000, 1'b0);
        add_word(-64'sd1_000_000_000_000_000_000, 1'b0);
        add_word(64'sd1234567890, 1'b0);
        add_word(-64'sd987654321, 1'b0);
        add_word(64'h5555_5555_5555_5555, 1'b0);
        add_word(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
        add_word(64'sd0, 1'b1);
        add_word(-64'sd9, 1'b0);

        repeat (270) add_word(rand_value(), $urandom_range(0, 39) == 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sampled mid-cycle, once the sender's updates have settled
        while (word_q.size() > 0 || i_valid || text_q.size() > 0) @(negedge i_clk);
        repeat (100) @(posedge i_clk);

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #16_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ signed_int_to_decimal_ascii_top.f @@
rtl/sitda_pkg.sv
rtl/sitda_ctrl.sv
rtl/sitda_dp.sv
rtl/signed_int_to_decimal_ascii_top.sv
tb/sv/signed_int_to_decimal_ascii_top_tb.sv
